>>> hw/rtl/lock_order_cycle_checker_defines.svh
// ----------------------------------------------------------------------------
// Lock order checker assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOCK_ORDER_CYCLE_CHECKER_DEFINES_SVH
`define LOCK_ORDER_CYCLE_CHECKER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define LOC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent
`define LOC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/loc_pkg.sv
// ----------------------------------------------------------------------------
// Lock order checker package
// Field widths, status and opcode values, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package loc_pkg;

   localparam int LOCK_W   = 6;
   localparam int STATUS_W = 3;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_OK         = 3'd0;
   localparam status_type ST_EMPTY      = 3'd1;
   localparam status_type ST_MISMATCH   = 3'd2;
   localparam status_type ST_DEADLOCK   = 3'd3;
   localparam status_type ST_STACK_FULL = 3'd4;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       take_req;
      logic       sel_walk;
      logic       capture_row;
      logic       start_walk;
      logic       walk_step;
      logic       push;
      logic       pop;
      logic       add_edge;
      logic       set_result;
      status_type res_status;
      logic       res_use_top;
      logic       res_fresh;
      logic       load_rsp;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_release;
      logic count_zero;
      logic count_full;
      logic top_match;
      logic edge_present;
      logic walk_found;
      logic walk_done;
      logic rsp_free;
   } sts_type;

endpackage

>>> hw/rtl/loc_if.sv
// ----------------------------------------------------------------------------
// Lock order checker channel interfaces
// Valid/ready channels for lock requests and check responses.
// ----------------------------------------------------------------------------
interface loc_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [loc_pkg::LOCK_W-1:0] lock_id;

   modport source (output valid, output op, output lock_id, input ready);
   modport sink (input valid, input op, input lock_id, output ready);
endinterface

interface loc_rsp_if;
   logic                       valid;
   logic                       ready;
   loc_pkg::status_type        status;
   logic [loc_pkg::LOCK_W-1:0] held_lock;
   logic                       new_edge;

   modport source (output valid, output status, output held_lock, output new_edge,
                   input ready);
   modport sink (input valid, input status, input held_lock, input new_edge,
                 output ready);
endinterface

>>> hw/rtl/loc_dp.sv
// ----------------------------------------------------------------------------
// Lock order checker datapath
// Lock stack, order edge memory, reachability walk and response register.
// ----------------------------------------------------------------------------
`include "lock_order_cycle_checker_defines.svh"

module loc_dp #(
   parameter int NUM_LOCKS   = 64,
   parameter int STACK_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  loc_pkg::cmd_type               cmd,
   output loc_pkg::sts_type               sts,
   input  logic                           req_op,
   input  logic [loc_pkg::LOCK_W-1:0]     req_lock_id,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output loc_pkg::status_type            rsp_status,
   output logic [loc_pkg::LOCK_W-1:0]     rsp_held_lock,
   output logic                           rsp_new_edge
);
   import loc_pkg::*;

   localparam int IdW  = $clog2(NUM_LOCKS);
   localparam int SpW  = $clog2(STACK_DEPTH);
   localparam int CntW = $clog2(STACK_DEPTH + 1);
   localparam int LutN = 2 ** LOCK_W;

   // Memories
   logic [IdW-1:0]       stack_mem [STACK_DEPTH];
   logic [NUM_LOCKS-1:0] edge_mem  [NUM_LOCKS];

   // Registers
   logic                 op_ff, op_in;
   logic [IdW-1:0]       id_ff, id_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [IdW-1:0]       stack_top_ff;
   logic [NUM_LOCKS-1:0] edge_row_ff;
   logic                 row_vld_rd_ff;
   logic [NUM_LOCKS-1:0] row_valid_ff, row_valid_in;
   logic [NUM_LOCKS-1:0] row_hold_ff, row_hold_in;
   logic [NUM_LOCKS-1:0] visited_ff, visited_in;
   logic [NUM_LOCKS-1:0] pending_ff, pending_in;
   logic                 inflight_ff, inflight_in;
   status_type           res_status_ff, res_status_in;
   logic [LOCK_W-1:0]    res_held_ff, res_held_in;
   logic                 res_fresh_ff, res_fresh_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [LOCK_W-1:0]    rsp_held_ff, rsp_held_in;
   logic                 rsp_fresh_ff, rsp_fresh_in;

   // Combinational signals
   logic [IdW-1:0]       wrap_lut [LutN];
   logic [SpW-1:0]       top_idx;
   logic [SpW-1:0]       push_idx;
   logic [NUM_LOCKS-1:0] row_eff;
   logic [NUM_LOCKS-1:0] id_bit;
   logic [IdW-1:0]       pick_idx;
   logic [NUM_LOCKS-1:0] pick_bit;
   logic [NUM_LOCKS-1:0] absorb;
   logic [IdW-1:0]       rd_addr;

   // Reduce raw lock ids into the lock range
   for (genvar g = 0; g < LutN; g++) begin : g_wrap
      assign wrap_lut[g] = IdW'(g % NUM_LOCKS);
   end

   assign top_idx  = SpW'(count_ff - 1'b1);
   assign push_idx = count_ff[SpW-1:0];
   assign row_eff  = row_vld_rd_ff ? edge_row_ff : '0;
   assign id_bit   = NUM_LOCKS'(1) << id_ff;
   assign pick_bit = NUM_LOCKS'(1) << pick_idx;
   assign absorb   = inflight_ff ? row_eff : '0;
   assign rd_addr  = cmd.sel_walk ? pick_idx : stack_top_ff;

   // Pick the lowest pending lock for the next row read
   always_comb begin
      pick_idx = '0;
      for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            pick_idx = IdW'(i);
         end
      end
   end

   // Report status to the controller
   always_comb begin
      sts.is_release   = (op_ff == OP_RELEASE);
      sts.count_zero   = (count_ff == '0);
      sts.count_full   = (count_ff == CntW'(STACK_DEPTH));
      sts.top_match    = (stack_top_ff == id_ff);
      sts.edge_present = row_eff[id_ff];
      sts.walk_found   = visited_ff[stack_top_ff];
      sts.walk_done    = (pending_ff == '0) && !inflight_ff;
      sts.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // Compute next register values
   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      count_in      = count_ff;
      row_valid_in  = row_valid_ff;
      row_hold_in   = row_hold_ff;
      visited_in    = visited_ff;
      pending_in    = pending_ff;
      inflight_in   = 1'b0;
      res_status_in = res_status_ff;
      res_held_in   = res_held_ff;
      res_fresh_in  = res_fresh_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_held_in   = rsp_held_ff;
      rsp_fresh_in  = rsp_fresh_ff;

      // Latch the request
      if (cmd.take_req) begin
         op_in = req_op;
         id_in = wrap_lut[req_lock_id];
      end

      // Push or pop the lock stack
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end

      // Hold the row of the held lock for the later edge insert
      if (cmd.capture_row) begin
         row_hold_in = row_eff;
      end

      if (cmd.add_edge) begin
         row_valid_in[stack_top_ff] = 1'b1;
      end

      // Seed or advance the reachability walk
      if (cmd.start_walk) begin
         visited_in = id_bit;
         pending_in = id_bit;
      end else if (cmd.walk_step) begin
         visited_in  = visited_ff | absorb;
         pending_in  = (pending_ff & ~pick_bit) | (absorb & ~visited_ff);
         inflight_in = (pending_ff != '0);
      end

      // Record the outcome of the transaction
      if (cmd.set_result) begin
         res_status_in = cmd.res_status;
         res_held_in   = cmd.res_use_top ? LOCK_W'(stack_top_ff) : '0;
         res_fresh_in  = cmd.res_fresh;
      end

      // Drive the response register
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_held_in   = res_held_ff;
         rsp_fresh_in  = res_fresh_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         row_valid_ff <= '0;
         visited_ff   <= '0;
         pending_ff   <= '0;
         inflight_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         row_valid_ff <= row_valid_in;
         visited_ff   <= visited_in;
         pending_ff   <= pending_in;
         inflight_ff  <= inflight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      row_hold_ff   <= row_hold_in;
      res_status_ff <= res_status_in;
      res_held_ff   <= res_held_in;
      res_fresh_ff  <= res_fresh_in;
      rsp_status_ff <= rsp_status_in;
      rsp_held_ff   <= rsp_held_in;
      rsp_fresh_ff  <= rsp_fresh_in;
   end

   // Lock stack memory: write on push, read the top every cycle
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[push_idx] <= id_ff;
      end
      stack_top_ff <= stack_mem[top_idx];
   end

   // Order edge memory: insert a new successor, read one row every cycle
   always_ff @(posedge clock) begin
      if (cmd.add_edge) begin
         edge_mem[stack_top_ff] <= row_hold_ff | id_bit;
      end
      edge_row_ff   <= edge_mem[rd_addr];
      row_vld_rd_ff <= row_valid_ff[rd_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_held_lock = rsp_held_ff;
   assign rsp_new_edge  = rsp_fresh_ff;

   // Assertions
   `LOC_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CntW'(STACK_DEPTH), "stack count overflow")
   `LOC_ASSERT_NOW(a_pending_visited, 1'b1, (pending_ff & ~visited_ff) == '0, "stray pending")
   `LOC_ASSERT_NEXT(a_push_grows, cmd.push, count_ff == $past(count_ff) + 1'b1, "push lost")
   `LOC_ASSERT_NOW(a_push_room, cmd.push, count_ff < CntW'(STACK_DEPTH), "push on full stack")

endmodule

>>> hw/rtl/loc_ctrl.sv
// ----------------------------------------------------------------------------
// Lock order checker controller
// Sequences stack checks, edge lookup, reachability walk and response.
// ----------------------------------------------------------------------------
`include "lock_order_cycle_checker_defines.svh"

module loc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  loc_pkg::sts_type sts,
   output loc_pkg::cmd_type cmd
);
   import loc_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TOP  = 3'd1;
   localparam logic [2:0] S_ROW  = 3'd2;
   localparam logic [2:0] S_WALK = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;

   // Decode state into datapath commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_TOP;
            end
         end

         // Stack top is ready: settle releases and simple acquires
         S_TOP: begin
            if (sts.is_release) begin
               cmd.set_result = 1'b1;
               state_in       = S_DONE;
               if (sts.count_zero) begin
                  cmd.res_status = ST_EMPTY;
               end else if (!sts.top_match) begin
                  cmd.res_status = ST_MISMATCH;
               end else begin
                  cmd.res_status = ST_OK;
                  cmd.pop        = 1'b1;
               end
            end else if (sts.count_full) begin
               cmd.set_result  = 1'b1;
               cmd.res_status  = ST_STACK_FULL;
               cmd.res_use_top = !sts.count_zero;
               state_in        = S_DONE;
            end else if (sts.count_zero || sts.top_match) begin
               cmd.set_result  = 1'b1;
               cmd.res_status  = ST_OK;
               cmd.res_use_top = !sts.count_zero;
               cmd.push        = 1'b1;
               state_in        = S_DONE;
            end else begin
               state_in = S_ROW;
            end
         end

         // Row of the held lock is ready: known edge or start the walk
         S_ROW: begin
            cmd.capture_row = 1'b1;
            if (sts.edge_present) begin
               cmd.set_result  = 1'b1;
               cmd.res_status  = ST_OK;
               cmd.res_use_top = 1'b1;
               cmd.push        = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.start_walk = 1'b1;
               state_in       = S_WALK;
            end
         end

         // Expand reachability from the new lock one row per cycle
         S_WALK: begin
            cmd.sel_walk = 1'b1;
            if (sts.walk_found) begin
               cmd.set_result  = 1'b1;
               cmd.res_status  = ST_DEADLOCK;
               cmd.res_use_top = 1'b1;
               state_in        = S_DONE;
            end else if (sts.walk_done) begin
               cmd.set_result  = 1'b1;
               cmd.res_status  = ST_OK;
               cmd.res_use_top = 1'b1;
               cmd.res_fresh   = 1'b1;
               cmd.add_edge    = 1'b1;
               cmd.push        = 1'b1;
               state_in        = S_DONE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end

         // Hand the result to the response register
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Assertions
   `LOC_ASSERT_NEXT(a_found_ends, (state_ff == S_WALK) && sts.walk_found, state_ff == S_DONE, "walk kept running after hit")
   `LOC_ASSERT_NOW(a_load_free, cmd.load_rsp, sts.rsp_free, "response overwritten")
   `LOC_ASSERT_NOW(a_one_update, 1'b1, !(cmd.push && cmd.pop), "push and pop together")

endmodule

>>> hw/rtl/lock_order_cycle_checker.sv
// ----------------------------------------------------------------------------
// Lock order checker
// Tracks held locks on a stack and flags lock order cycles as deadlocks.
// ----------------------------------------------------------------------------
// One transaction at a time. A release, a stack-full acquire, an acquire with
// an empty stack and a recursive acquire settle in the top state. An acquire
// whose order edge is already recorded settles in the row state. An acquire
// that meets an unseen edge runs a reachability walk over the order edge
// memory, one read of a single successor row per cycle; the walk idles
// whenever the pending set runs dry while a row read is still in flight. A
// deadlock ends the walk as soon as the held lock is reached. The edge memory
// has a single read port. Each result passes through the done state into an
// output register, so the next request is accepted while it waits to be
// taken; a result that is still held stalls the following one in its done
// state. Edge rows clear at reset through one valid flag per lock, so no
// clearing pass is needed.

module lock_order_cycle_checker #(
   parameter int NUM_LOCKS   = 64,
   parameter int STACK_DEPTH = 16
) (
   input logic     clock,
   input logic     reset,
   loc_req_if.sink req_chan,
   loc_rsp_if.source rsp_chan
);
   import loc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequence each transaction
   loc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold stack, edges and walk state
   loc_dp #(
      .NUM_LOCKS   (NUM_LOCKS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_op        (req_chan.op),
      .req_lock_id   (req_chan.lock_id),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_status    (rsp_chan.status),
      .rsp_held_lock (rsp_chan.held_lock),
      .rsp_new_edge  (rsp_chan.new_edge)
   );

endmodule

>>> test/tb_lock_order_cycle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lock order checker testbench
// Drives acquire and release requests through the request channel and checks
// every response against a behavioral model of the lock stack and the lock
// order graph. A short directed run hits the corner cases. Random phases
// follow: nested acquire/release runs over small lock pools, long lock chains
// and wide random picks, mixed with stray requests. Both channels idle at
// random, the response side holds off once for a long stretch, and the
// request side pauses once until all responses have drained.
// ----------------------------------------------------------------------------
module tb_lock_order_cycle_checker;
   import loc_pkg::*;

   localparam int NUM_LOCKS   = 64;
   localparam int STACK_DEPTH = 16;
   localparam int RANDOM_REQS = 1900;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 500;
   localparam int HOLD_AT     = 400;
   localparam int PAUSE_AT    = 1000;
   localparam int CALM_FROM   = 900;
   localparam int CALM_TO     = 1200;
   localparam int TAIL_CYCLES = 100;
   localparam int MAX_REPORTS = 40;

   // Two copies of the model state: the generator's view and the checker's
   localparam int GEN_VIEW = 0;
   localparam int CHK_VIEW = 1;

   typedef struct packed {
      status_type        status;
      logic [LOCK_W-1:0] held;
      logic              fresh;
   } outcome_type;

   typedef struct packed {
      logic              op;
      logic [LOCK_W-1:0] lock_id;
      logic              drain;
   } lock_request_type;

   logic clock;
   logic reset;

   loc_req_if lock_req ();
   loc_rsp_if lock_rsp ();

   lock_order_cycle_checker #(
      .NUM_LOCKS   (NUM_LOCKS),
      .STACK_DEPTH (STACK_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (lock_req),
      .rsp_chan (lock_rsp)
   );

   // Model state
   logic [NUM_LOCKS-1:0] edge_rows [2][NUM_LOCKS];
   logic [LOCK_W-1:0]    held_stack [2][STACK_DEPTH];
   int unsigned          held_count [2];

   lock_request_type pending_requests [$];
   outcome_type      awaited_results [$];
   lock_request_type next_request;
   outcome_type      oldest_result;

   int  mismatch_count;
   int  accepted_count;
   int  cycle_count;
   int  hold_left;
   bit  hold_done;
   bit  pause_next;
   bit  req_taken;
   bit  calm;

   // Clock generation
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Reachability walk over the order graph, one frontier step per pass
   function automatic bit lock_reaches(input int w, input logic [LOCK_W-1:0] from_lock,
                                       input logic [LOCK_W-1:0] to_lock);
      logic [NUM_LOCKS-1:0] reached;
      logic [NUM_LOCKS-1:0] grown;
      reached = '0;
      reached[from_lock] = 1'b1;
      for (int step = 0; step < NUM_LOCKS; step++) begin
         grown = reached;
         for (int i = 0; i < NUM_LOCKS; i++) begin
            if (reached[i]) grown |= edge_rows[w][i];
         end
         if (grown == reached) break;
         reached = grown;
      end
      return reached[to_lock];
   endfunction

   // Apply one request to a model view and return its response
   function automatic outcome_type apply_lock_op(input int w, input logic op,
                                                 input logic [LOCK_W-1:0] lock_id);
      outcome_type       res;
      logic [LOCK_W-1:0] top;
      res = '0;
      res.status = ST_OK;
      if (op == OP_ACQUIRE) begin
         if (held_count[w] >= STACK_DEPTH) begin
            res.status = ST_STACK_FULL;
            res.held = held_stack[w][held_count[w]-1];
         end else begin
            if (held_count[w] > 0) begin
               top = held_stack[w][held_count[w]-1];
               res.held = top;
               // Only an unseen edge to a different lock needs the walk
               if (top != lock_id && !edge_rows[w][top][lock_id]) begin
                  if (lock_reaches(w, lock_id, top)) begin
                     res.status = ST_DEADLOCK;
                  end else begin
                     edge_rows[w][top][lock_id] = 1'b1;
                     res.fresh = 1'b1;
                  end
               end
            end
            if (res.status == ST_OK) begin
               held_stack[w][held_count[w]] = lock_id;
               held_count[w]++;
            end
         end
      end else begin
         if (held_count[w] == 0) begin
            res.status = ST_EMPTY;
         end else if (held_stack[w][held_count[w]-1] != lock_id) begin
            res.status = ST_MISMATCH;
         end else begin
            held_count[w]--;
         end
      end
      return res;
   endfunction

   // Queue one request and advance the generator's view
   task automatic add_request(input logic op, input logic [LOCK_W-1:0] lock_id);
      lock_request_type item;
      outcome_type      ignored;
      item.op = op;
      item.lock_id = lock_id;
      item.drain = pause_next;
      pause_next = 1'b0;
      pending_requests.push_back(item);
      ignored = apply_lock_op(GEN_VIEW, op, lock_id);
   endtask

   function automatic logic [LOCK_W-1:0] gen_top();
      return (held_count[GEN_VIEW] > 0) ? held_stack[GEN_VIEW][held_count[GEN_VIEW]-1] : '0;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch %0d: %s got %0d expected %0d", accepted_count, what, got, want);
   endtask

   // Fill the request queue: directed corner cases, then random phases
   task automatic build_stimulus();
      int                kind;
      int                span;
      int                depth_cap;
      int                pool_n;
      int                roll;
      logic [LOCK_W-1:0] pool [8];
      logic [LOCK_W-1:0] chain_next;
      logic [LOCK_W-1:0] pick;

      // Empty release, recursion, new edge, mismatch, known edge
      add_request(OP_RELEASE, 6'd5);
      add_request(OP_ACQUIRE, 6'd0);
      add_request(OP_ACQUIRE, 6'd0);
      add_request(OP_ACQUIRE, 6'd63);
      add_request(OP_RELEASE, 6'd0);
      add_request(OP_RELEASE, 6'd63);
      add_request(OP_ACQUIRE, 6'd63);
      add_request(OP_RELEASE, 6'd63);
      add_request(OP_RELEASE, 6'd0);
      add_request(OP_RELEASE, 6'd0);
      // Reverse order closes a cycle
      add_request(OP_ACQUIRE, 6'd63);
      add_request(OP_ACQUIRE, 6'd0);
      // Fill the stack by recursion, then overflow it
      for (int i = 0; i < STACK_DEPTH - 1; i++) add_request(OP_ACQUIRE, 6'd63);
      add_request(OP_ACQUIRE, 6'd1);

      // Random phases with well-formed nesting and some noise
      chain_next = LOCK_W'($urandom_range(0, NUM_LOCKS-1));
      while (pending_requests.size() < RANDOM_REQS + 28) begin
         kind = $urandom_range(0, 9);
         span = $urandom_range(20, 60);
         depth_cap = $urandom_range(1, STACK_DEPTH + 1);
         pool_n = $urandom_range(3, 8);
         for (int k = 0; k < 8; k++) pool[k] = LOCK_W'($urandom_range(0, NUM_LOCKS-1));
         for (int n = 0; n < span; n++) begin
            if (pending_requests.size() >= PAUSE_AT && !pause_next && PAUSE_AT > 0
                && pending_requests.size() < PAUSE_AT + 1)
               pause_next = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
               add_request(1'($urandom_range(0, 1)), LOCK_W'($urandom_range(0, NUM_LOCKS-1)));
            end else if (held_count[GEN_VIEW] == 0
                         || (roll < 55 && held_count[GEN_VIEW] < depth_cap)) begin
               if (held_count[GEN_VIEW] > 0 && $urandom_range(0, 9) == 0) begin
                  pick = gen_top();
               end else if (kind <= 5) begin
                  pick = pool[$urandom_range(0, pool_n-1)];
               end else if (kind <= 7) begin
                  pick = chain_next;
                  chain_next = chain_next + 1'b1;
               end else begin
                  pick = LOCK_W'($urandom_range(0, NUM_LOCKS-1));
               end
               add_request(OP_ACQUIRE, pick);
            end else begin
               add_request(OP_RELEASE, gen_top());
            end
         end
      end
   endtask

   // Accept requests, predict responses and check them at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
         if (lock_req.valid && lock_req.ready) begin
            awaited_results.push_back(apply_lock_op(CHK_VIEW, lock_req.op, lock_req.lock_id));
            accepted_count++;
            req_taken = 1'b1;
         end
         if (lock_rsp.valid && lock_rsp.ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected response, status", int'(lock_rsp.status), 0);
            end else begin
               oldest_result = awaited_results.pop_front();
               if (lock_rsp.status !== oldest_result.status)
                  report_mismatch("status", int'(lock_rsp.status),
                                  int'(oldest_result.status));
               if (lock_rsp.held_lock !== oldest_result.held)
                  report_mismatch("held_lock", int'(lock_rsp.held_lock),
                                  int'(oldest_result.held));
               if (lock_rsp.new_edge !== oldest_result.fresh)
                  report_mismatch("new_edge", int'(lock_rsp.new_edge),
                                  int'(oldest_result.fresh));
            end
         end
      end
   end

   // Drive requests at the falling edge; hold a request until it is taken
   always @(negedge clock) begin
      if (!reset) begin
         calm = (accepted_count >= CALM_FROM) && (accepted_count < CALM_TO);
         if (lock_req.valid && !req_taken) begin
            // hold the current transaction
         end else if (pending_requests.size() == 0
                      || (pending_requests[0].drain && awaited_results.size() != 0)
                      || (!calm && $urandom_range(0, 99) < 23)) begin
            lock_req.valid <= 1'b0;
         end else begin
            next_request = pending_requests.pop_front();
            lock_req.valid   <= 1'b1;
            lock_req.op      <= next_request.op;
            lock_req.lock_id <= next_request.lock_id;
         end
         req_taken = 1'b0;
      end
   end

   // Response ready: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            lock_rsp.ready <= 1'b0;
         end else begin
            lock_rsp.ready <= calm || ($urandom_range(0, 99) >= 23);
         end
      end
   end

   // Reset, run the stimulus, drain and report
   initial begin
      reset = 1'b1;
      lock_req.valid = 1'b0;
      lock_req.op = OP_ACQUIRE;
      lock_req.lock_id = '0;
      lock_rsp.ready = 1'b0;
      mismatch_count = 0;
      accepted_count = 0;
      cycle_count = 0;
      hold_left = 0;
      hold_done = 1'b0;
      pause_next = 1'b0;
      req_taken = 1'b0;
      calm = 1'b0;
      for (int w = 0; w < 2; w++) begin
         held_count[w] = 0;
         for (int i = 0; i < NUM_LOCKS; i++) edge_rows[w][i] = '0;
         for (int i = 0; i < STACK_DEPTH; i++) held_stack[w][i] = '0;
      end
      build_stimulus();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_requests.size() != 0 || lock_req.valid) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
